// File: src/vrr_pkg.sv
// shared types, constants, sine table and helpers for the velocity reflection block
package vrr_pkg;

    localparam int SPEED_BITS     = 16;
    localparam int TRIG_FRAC_BITS = 15;

    localparam int VEL_IN_W = 16;
    localparam int ANG_W    = 9;
    localparam int REST_W   = 10;

    localparam int VEL_W  = VEL_IN_W + 1;
    localparam int TRIG_W = TRIG_FRAC_BITS + 2;
    localparam int GAIN_W = REST_W + 1;
    localparam int DOT_W  = TRIG_FRAC_BITS + VEL_W + 1;
    localparam int M_W    = DOT_W - 1;
    localparam int Q_W    = M_W + 1;
    localparam int MA_W   = Q_W;
    localparam int MB_W   = (TRIG_W > GAIN_W) ? TRIG_W + 1 : GAIN_W + 1;
    localparam int P_W    = MA_W + MB_W;
    localparam int ACC_W  = P_W;
    localparam int SHIFT  = TRIG_FRAC_BITS + 8;
    localparam int SAT_W  = (SPEED_BITS < VEL_IN_W) ? SPEED_BITS : VEL_IN_W;
    localparam int IDX_W  = 7;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(256);
    localparam logic [ANG_W:0]    ANG_90   = (ANG_W+1)'(90);
    localparam logic [ANG_W:0]    ANG_180  = (ANG_W+1)'(180);
    localparam logic [ANG_W:0]    ANG_270  = (ANG_W+1)'(270);
    localparam logic [ANG_W:0]    ANG_360  = (ANG_W+1)'(360);

    localparam logic [ACC_W-1:0] TRUNC_BIAS = ACC_W'((64'd1 << SHIFT) - 64'd1);
    localparam logic signed [ACC_W-1:0] SAT_HI = $signed(ACC_W'((64'd1 << (SAT_W - 1)) - 64'd1));
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - $signed(ACC_W'(1));

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // (k+1)(k+2) for the odd taylor steps k = 1..21, first step in the low slot
    localparam int TAYLOR_N = 11;
    localparam logic [TAYLOR_N-1:0][9:0] TAYLOR_DEN = {
        10'd506, 10'd420, 10'd342, 10'd272, 10'd210, 10'd156,
        10'd110, 10'd72, 10'd42, 10'd20, 10'd6
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIG,
        ST_MCX,
        ST_MSY,
        ST_DOT,
        ST_MCM,
        ST_MSM,
        ST_MGX,
        ST_MGY,
        ST_OUTX,
        ST_OUTY
    } t_state;

    typedef struct packed {
        logic signed [VEL_IN_W-1:0] new_vel_x;
        logic signed [VEL_IN_W-1:0] new_vel_y;
        logic                       old_vx_neg;
        logic                       old_vx_pos;
    } t_res;

    typedef logic [90:0][TRIG_FRAC_BITS:0] t_sin_tab;

    // taylor series in q30, rounded half up to the table format
    function automatic longint unsigned f_sin_quarter(input int unsigned d);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        bit              sub;
        x    = (longint'(d) * PI_Q30 + 64'd90) / 64'd180;
        term = x;
        sum  = longint'(x);
        sub  = 1'b1;
        for (int i = 0; i < TAYLOR_N; i++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 64'(TAYLOR_DEN[i]);
            if (sub) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
            sub = !sub;
        end
        if (sum < 0) begin
            sum = 0;
        end
        return (longint'(sum) + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    endfunction

    function automatic t_sin_tab f_build_tab();
        t_sin_tab        tab;
        longint unsigned v;
        for (int unsigned d = 0; d <= 90; d++) begin
            v      = f_sin_quarter(d);
            tab[d] = v[TRIG_FRAC_BITS:0];
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = f_build_tab();

    // sine of a whole-degree angle in 0..359 by quadrant symmetry
    function automatic logic signed [TRIG_W-1:0] f_sin_deg(input logic [ANG_W:0] a);
        logic [ANG_W:0]          d;
        logic                    neg;
        logic [TRIG_FRAC_BITS:0] mag;
        logic signed [TRIG_W-1:0] val;
        if (a <= ANG_90) begin
            d   = a;
            neg = 1'b0;
        end else if (a <= ANG_180) begin
            d   = ANG_180 - a;
            neg = 1'b0;
        end else if (a <= ANG_270) begin
            d   = a - ANG_180;
            neg = 1'b1;
        end else begin
            d   = ANG_360 - a;
            neg = 1'b1;
        end
        mag = SIN_TAB[d[IDX_W-1:0]];
        val = $signed({1'b0, mag});
        return neg ? -val : val;
    endfunction

    function automatic logic signed [VEL_IN_W-1:0] f_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end else begin
            r = v;
        end
        return r[VEL_IN_W-1:0];
    endfunction

    // divide by 2^SHIFT, rounding toward zero
    function automatic logic signed [ACC_W-1:0] f_trunc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] b;
        b = v + (v[ACC_W-1] ? $signed(TRUNC_BIAS) : $signed(ACC_W'(0)));
        return b >>> SHIFT;
    endfunction

endpackage

// File: src/velocity_reflect_restitution.sv
// Bounces a velocity off a ramp: the velocity is split against the surface normal and the
// normal part comes back scaled by the restitution factor, with the result rounded toward
// zero and clamped to 16-bit signed, and a facing-left flag tracks sign changes of vx.
// An input transaction is taken only while the core is idle; its result reaches the output
// register as the core leaves its last step, and the next transaction can be taken in the
// cycle after, so a new one is never taken before the last is through. The six multiplies
// (two for the dot product, two for the normal projection, two for the restitution gain)
// share one 33x18 multiplier with a registered product; table lookup and rounding take
// their own steps. A result waiting on a stalled output holds the core in its last step.
module velocity_reflect_restitution (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [vrr_pkg::VEL_IN_W-1:0] i_vel_x,
    input  logic signed [vrr_pkg::VEL_IN_W-1:0] i_vel_y,
    input  logic [vrr_pkg::ANG_W-1:0]           i_surface_angle_deg,
    input  logic [vrr_pkg::REST_W-1:0]          i_restitution,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [vrr_pkg::VEL_IN_W-1:0] o_new_vel_x,
    output logic signed [vrr_pkg::VEL_IN_W-1:0] o_new_vel_y,
    output logic                                o_facing_left_out
);
    import vrr_pkg::*;

    logic  busy;
    logic  done;
    logic  out_ready;
    t_res  res;
    logic  n_facing;

    logic                       r_out_valid;
    logic                       r_facing;
    logic signed [VEL_IN_W-1:0] r_new_vel_x;
    logic signed [VEL_IN_W-1:0] r_new_vel_y;

    assign o_in_stall = busy;
    assign out_ready  = !r_out_valid || !i_out_stall;

    vrr_core u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_in_valid && !busy),
        .i_vel_x             (i_vel_x),
        .i_vel_y             (i_vel_y),
        .i_surface_angle_deg (i_surface_angle_deg),
        .i_restitution       (i_restitution),
        .i_out_ready         (out_ready),
        .o_busy              (busy),
        .o_done              (done),
        .o_res               (res)
    );

    always_comb begin
        n_facing = r_facing;
        if (!res.old_vx_neg && res.new_vel_x[VEL_IN_W-1]) begin
            n_facing = 1'b1;
        end else if (!res.old_vx_pos && !res.new_vel_x[VEL_IN_W-1]
                     && (res.new_vel_x != '0)) begin
            n_facing = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_facing    <= 1'b0;
        end else begin
            if (done) begin
                r_out_valid <= 1'b1;
                r_facing    <= n_facing;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_new_vel_x <= res.new_vel_x;
            r_new_vel_y <= res.new_vel_y;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_new_vel_x       = r_new_vel_x;
    assign o_new_vel_y       = r_new_vel_y;
    assign o_facing_left_out = r_facing;

endmodule

// File: src/vrr_mul.sv
// shared signed multiplier with registered product
module vrr_mul (
    input  logic                            i_clk,
    input  logic signed [vrr_pkg::MA_W-1:0] i_a,
    input  logic signed [vrr_pkg::MB_W-1:0] i_b,
    output logic signed [vrr_pkg::P_W-1:0]  o_p
);
    import vrr_pkg::*;

    logic signed [P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= P_W'(i_a) * P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: src/vrr_core.sv
// sequencer and datapath around the shared multiplier
module vrr_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [vrr_pkg::VEL_IN_W-1:0] i_vel_x,
    input  logic signed [vrr_pkg::VEL_IN_W-1:0] i_vel_y,
    input  logic [vrr_pkg::ANG_W-1:0]           i_surface_angle_deg,
    input  logic [vrr_pkg::REST_W-1:0]          i_restitution,
    input  logic                                i_out_ready,
    output logic                                o_busy,
    output logic                                o_done,
    output vrr_pkg::t_res                       o_res
);
    import vrr_pkg::*;

    t_state r_state;
    t_state n_state;

    logic signed [VEL_W-1:0]   r_vx;
    logic signed [VEL_W-1:0]   r_vy;
    logic [ANG_W-1:0]          r_ang;
    logic [GAIN_W-1:0]         r_gain;
    logic signed [TRIG_W-1:0]  r_c;
    logic signed [TRIG_W-1:0]  r_s;
    logic signed [DOT_W-1:0]   r_dot;
    logic [M_W-1:0]            r_m;
    logic signed [Q_W-1:0]     r_qx;
    logic signed [Q_W-1:0]     r_qy;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [VEL_IN_W-1:0] r_nx;

    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [P_W-1:0]     p;

    logic [ANG_W:0]            ang_n;
    logic [ANG_W:0]            ang_s;
    logic [ANG_W:0]            ang_c0;
    logic [ANG_W:0]            ang_c;
    logic signed [DOT_W-1:0]   dot_sum;
    logic signed [DOT_W-1:0]   dot_abs;
    logic [M_W-1:0]            q_mag;
    logic signed [Q_W-1:0]     q_pos;
    logic signed [TRIG_W-1:0]  c_abs;
    logic signed [TRIG_W-1:0]  s_abs;
    logic signed [ACC_W-1:0]   ny_full;

    vrr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (p)
    );

    // normal angle and its quarter-turn for the cosine
    always_comb begin
        ang_n  = {1'b0, r_ang} + ANG_90;
        ang_s  = (ang_n >= ANG_360) ? ang_n - ANG_360 : ang_n;
        ang_c0 = ang_s + ANG_90;
        ang_c  = (ang_c0 >= ANG_360) ? ang_c0 - ANG_360 : ang_c0;
    end

    always_comb begin
        dot_sum = r_dot + p[DOT_W-1:0];
        dot_abs = dot_sum[DOT_W-1] ? -dot_sum : dot_sum;
        q_mag   = p[TRIG_FRAC_BITS+M_W-1:TRIG_FRAC_BITS];
        q_pos   = $signed({1'b0, q_mag});
        c_abs   = r_c[TRIG_W-1] ? -r_c : r_c;
        s_abs   = r_s[TRIG_W-1] ? -r_s : r_s;
        ny_full = -f_trunc(r_acc);
    end

    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        o_done  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_TRIG;
                end
            end
            ST_TRIG: n_state = ST_MCX;
            ST_MCX: begin
                mul_a   = MA_W'(r_vx);
                mul_b   = MB_W'(r_c);
                n_state = ST_MSY;
            end
            ST_MSY: begin
                mul_a   = MA_W'(r_vy);
                mul_b   = MB_W'(r_s);
                n_state = ST_DOT;
            end
            ST_DOT: n_state = ST_MCM;
            ST_MCM: begin
                mul_a   = $signed({1'b0, r_m});
                mul_b   = MB_W'(c_abs);
                n_state = ST_MSM;
            end
            ST_MSM: begin
                mul_a   = $signed({1'b0, r_m});
                mul_b   = MB_W'(s_abs);
                n_state = ST_MGX;
            end
            ST_MGX: begin
                mul_a   = r_qx;
                mul_b   = $signed(MB_W'(r_gain));
                n_state = ST_MGY;
            end
            ST_MGY: begin
                mul_a   = r_qy;
                mul_b   = $signed(MB_W'(r_gain));
                n_state = ST_OUTX;
            end
            ST_OUTX: n_state = ST_OUTY;
            ST_OUTY: begin
                if (i_out_ready) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_vx   <= VEL_W'(i_vel_x);
                    r_vy   <= -VEL_W'(i_vel_y);
                    r_ang  <= i_surface_angle_deg;
                    r_gain <= GAIN_ONE + GAIN_W'(i_restitution);
                end
            end
            ST_TRIG: begin
                r_c <= f_sin_deg(ang_c);
                r_s <= f_sin_deg(ang_s);
            end
            ST_MSY: r_dot <= p[DOT_W-1:0];
            ST_DOT: r_m <= dot_abs[M_W-1:0];
            ST_MSM: r_qx <= r_c[TRIG_W-1] ? -q_pos : q_pos;
            ST_MGX: r_qy <= r_s[TRIG_W-1] ? -q_pos : q_pos;
            ST_MGY: r_acc <= (ACC_W'(r_vx) <<< SHIFT) + p;
            ST_OUTX: begin
                r_nx  <= f_sat(f_trunc(r_acc));
                r_acc <= (ACC_W'(r_vy) <<< SHIFT) + p;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        o_res.new_vel_x  = r_nx;
        o_res.new_vel_y  = f_sat(ny_full);
        o_res.old_vx_neg = r_vx[VEL_W-1];
        o_res.old_vx_pos = !r_vx[VEL_W-1] && (r_vx != '0);
    end

endmodule
